FILE: rtl/dmtg_pkg.sv
package dmtg_pkg;

	// Register indexes on the configuration port.
	localparam int unsigned CFG_INDEX_BITS = 3;
	typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

	localparam cfg_index_t REG_NATURAL_PERIOD    = 3'd0;
	localparam cfg_index_t REG_CORRECTION_PERIOD = 3'd1;
	localparam cfg_index_t REG_NATURAL_ERROR     = 3'd2;
	localparam cfg_index_t REG_CORRECTION_ERROR  = 3'd3;
	localparam cfg_index_t REG_SKEW_LIMIT        = 3'd4;
	localparam cfg_index_t REG_ERROR_RESTART     = 3'd5;

	// Register reset values.
	localparam logic [15:0] RST_NATURAL_PERIOD    = 16'd33;
	localparam logic [15:0] RST_CORRECTION_PERIOD = 16'd32;
	localparam logic [15:0] RST_NATURAL_ERROR     = 16'd15204;
	localparam logic [15:0] RST_CORRECTION_ERROR  = 16'd50332;
	localparam logic [15:0] RST_SKEW_LIMIT        = 16'd50332;
	localparam logic [15:0] RST_ERROR_RESTART     = 16'd40370;

	// Item modes.
	localparam logic MODE_TICK  = 1'b0;
	localparam logic MODE_DELAY = 1'b1;

	typedef struct packed {
		logic        mode;
		logic [15:0] delay_count;
	} dmtg_in_t;

	typedef struct packed {
		logic        ms_tick;
		logic        delay_done;
		logic [31:0] system_time;
		logic [15:0] error_value;
	} dmtg_out_t;

	typedef struct packed {
		logic [15:0] natural_period;
		logic [15:0] correction_period;
		logic [15:0] natural_error;
		logic [15:0] correction_error;
		logic [15:0] skew_limit;
		logic [15:0] error_restart;
	} dmtg_cfg_t;

	// Status from the period scheduler for the item being processed.
	typedef struct packed {
		logic        ms_tick;
		logic [15:0] error_value;
	} dmtg_sched_t;

endpackage

FILE: rtl/dmtg_sched.sv
module dmtg_sched import dmtg_pkg::*; #(
	parameter int COUNTER_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dmtg_cfg_t   cfg,
	input  logic        step,
	output dmtg_sched_t status
);

	logic [COUNTER_BITS-1:0] counter_q;
	logic [COUNTER_BITS-1:0] compare_q;
	logic [15:0]             acc_q;

	logic [COUNTER_BITS-1:0] counter_nxt;
	logic [COUNTER_BITS-1:0] compare_nxt;
	logic [15:0]             acc_nxt;
	logic                    match;

	// Pick the next period on a match; a wrap of the counter then restarts the schedule.
	always_comb begin
		counter_nxt = counter_q + COUNTER_BITS'(1);
		match       = step && (counter_nxt == compare_q);
		compare_nxt = compare_q;
		acc_nxt     = acc_q;
		if (match) begin
			if (acc_q < cfg.skew_limit) begin
				compare_nxt = compare_q + COUNTER_BITS'(cfg.natural_period);
				acc_nxt     = acc_q + cfg.natural_error;
			end else begin
				compare_nxt = compare_q + COUNTER_BITS'(cfg.correction_period);
				acc_nxt     = acc_q - cfg.correction_error;
			end
		end
		if (step && (counter_nxt == '0)) begin
			compare_nxt = COUNTER_BITS'(cfg.natural_period);
			acc_nxt     = cfg.error_restart;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
			compare_q <= COUNTER_BITS'(RST_NATURAL_PERIOD);
			acc_q     <= RST_ERROR_RESTART;
		end else if (step) begin
			counter_q <= counter_nxt;
			compare_q <= compare_nxt;
			acc_q     <= acc_nxt;
		end
	end

	assign status.ms_tick     = match;
	assign status.error_value = acc_nxt;

endmodule

FILE: rtl/dual_modulus_ms_tick_generator.sv
// Channel   Direction  Handshake           Payload
// in        to block   in_valid/in_stall   dmtg_in_t  (mode, delay_count)
// out       from block out_valid/out_stall dmtg_out_t (ms_tick, delay_done, system_time,
//                                                      error_value)
// cfg       to block   cfg_valid/cfg_ready cfg_index, cfg_data (16-bit register value)
//
// Every item passes through the input register and then through the scheduling logic into
// the result register. A new item is taken every cycle unless the input stall is raised.
// Reset is asynchronous; it clears counters, schedule, config and valid flags, not data.
// A stall on the output holds the result register and, through it, the input register; the
// input stall rises only when the input register is full and cannot move on.
module dual_modulus_ms_tick_generator import dmtg_pkg::*; #(
	parameter int COUNTER_BITS = 16,
	parameter int TIME_BITS    = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  dmtg_in_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output dmtg_out_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  cfg_index_t  cfg_index,
	input  logic [15:0] cfg_data
);

	// Configuration registers. Writes are to be made only while the block is idle; the block
	// does not enforce this. They are always accepted and take effect on the next item.
	dmtg_cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.natural_period    <= RST_NATURAL_PERIOD;
			cfg_q.correction_period <= RST_CORRECTION_PERIOD;
			cfg_q.natural_error     <= RST_NATURAL_ERROR;
			cfg_q.correction_error  <= RST_CORRECTION_ERROR;
			cfg_q.skew_limit        <= RST_SKEW_LIMIT;
			cfg_q.error_restart     <= RST_ERROR_RESTART;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_NATURAL_PERIOD:    cfg_q.natural_period    <= cfg_data;
				REG_CORRECTION_PERIOD: cfg_q.correction_period <= cfg_data;
				REG_NATURAL_ERROR:     cfg_q.natural_error     <= cfg_data;
				REG_CORRECTION_ERROR:  cfg_q.correction_error  <= cfg_data;
				REG_SKEW_LIMIT:        cfg_q.skew_limit        <= cfg_data;
				REG_ERROR_RESTART:     cfg_q.error_restart     <= cfg_data;
				default: ;
			endcase
		end
	end

	// The whole pipeline moves whenever the result register is empty or its transfer
	// completes in this cycle. An empty input register takes a new item even while the
	// result register is held.
	logic     advance;
	logic     valid_s1;
	dmtg_in_t item_s1;

	assign advance  = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// An item is processed in the cycle it leaves the input register.
	logic        process;
	logic        tick_item;
	dmtg_sched_t sched;

	assign process   = advance && valid_s1;
	assign tick_item = process && (item_s1.mode == MODE_TICK);

	dmtg_sched #(
		.COUNTER_BITS(COUNTER_BITS)
	) u_sched (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.step   (tick_item),
		.status (sched)
	);

	// Millisecond time and the delay count-down, both moved on by each millisecond tick.
	// A delay command simply reloads the count; zero leaves no delay running.
	logic [TIME_BITS-1:0] elapsed_q;
	logic [TIME_BITS-1:0] elapsed_nxt;
	logic [15:0]          delay_q;
	logic [15:0]          delay_nxt;
	logic                 done;

	always_comb begin
		elapsed_nxt = elapsed_q;
		delay_nxt   = delay_q;
		done        = 1'b0;
		if (process && (item_s1.mode == MODE_DELAY)) begin
			delay_nxt = item_s1.delay_count;
		end else if (sched.ms_tick) begin
			elapsed_nxt = elapsed_q + TIME_BITS'(1);
			if (delay_q != 16'd0) begin
				delay_nxt = delay_q - 16'd1;
				done      = (delay_q == 16'd1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			delay_q   <= '0;
		end else if (process) begin
			elapsed_q <= elapsed_nxt;
			delay_q   <= delay_nxt;
		end
	end

	// Result register: loaded with each processed item, emptied by a completed transfer.
	logic [63:0] time_ext;

	assign time_ext = 64'(elapsed_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			out_data.ms_tick     <= sched.ms_tick;
			out_data.delay_done  <= done;
			out_data.system_time <= time_ext[31:0];
			out_data.error_value <= sched.error_value;
		end
	end

endmodule
